[sv/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants for the quadratic root solver
// Result status codes, default parameter values and the output width.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_W          = 40;

  typedef enum logic [1:0] {
    ST_TWO   = 2'd0,
    ST_ONE   = 2'd1,
    ST_NONE  = 2'd2,
    ST_AZERO = 2'd3
  } status_t;

endpackage

[sv/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c = 0 in fixed point
// Pipelined discriminant, square root and divider chains.
// ----------------------------------------------------------------------------
// Takes one coefficient transaction per cycle while the output is not stalled
// and returns one result per transaction, in order. Two stages form the
// discriminant, COEF_WIDTH+FRAC_BITS+1 square root cells each produce one root
// bit, one stage forms the numerators, COEF_WIDTH+FRAC_BITS+2 divider cells each
// produce one quotient bit of both roots, and the last stage signs, saturates,
// zeroes absent roots and holds the result. When the output stalls, the whole
// pipeline holds and in_ready drops.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COEF_WIDTH-1:0] coef_a,
  input  logic signed [COEF_WIDTH-1:0] coef_b,
  input  logic signed [COEF_WIDTH-1:0] coef_c,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   root_status,
  output logic signed [qrs_pkg::OUT_W-1:0] root_plus,
  output logic signed [qrs_pkg::OUT_W-1:0] root_minus
);

  localparam int CW   = COEF_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int OW   = qrs_pkg::OUT_W;
  localparam int DW   = 2 * CW + 2;
  localparam int SQW  = CW + F + 1;
  localparam int RADW = 2 * SQW;
  localparam int NW   = CW + F + 3;
  localparam int QW   = CW + F + 2;
  localparam int DENW = CW + 1;
  localparam int SW   = (QW + 1 > OW + 1) ? QW + 1 : OW + 1;
  localparam int SPW  = 2 + NW + DENW + 1;
  localparam int DPW  = 4;
  localparam logic signed [SW-1:0] OMAX = (SW'(1) <<< (OW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] OMIN = -(SW'(1) <<< (OW - 1));

  logic en;
  assign en       = !(out_valid && !out_ready);
  assign in_ready = en;

  // stage 1: products
  logic signed [2*CW-1:0] bb_w, ac_w;
  logic                   s1_valid;
  logic signed [DW-1:0]   s1_bb, s1_ac4;
  logic signed [CW-1:0]   s1_a, s1_b;

  assign bb_w = coef_b * coef_b;
  assign ac_w = coef_a * coef_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bb  <= DW'(bb_w);
      s1_ac4 <= DW'(ac_w) <<< 2;
      s1_a   <= coef_a;
      s1_b   <= coef_b;
    end
  end

  // stage 2: discriminant, classification, radicand
  logic signed [DW-1:0] disc;
  logic signed [NW-1:0] b_ext;
  logic signed [CW:0]   a_ext, a_mag;
  qrs_pkg::status_t     st_w;
  logic                 s2_valid;
  logic [RADW-1:0]      s2_rad;
  logic [SPW-1:0]       s2_pl;

  assign disc  = s1_bb - s1_ac4;
  assign b_ext = NW'(s1_b);
  assign a_ext = (CW + 1)'(s1_a);
  assign a_mag = a_ext[CW] ? -a_ext : a_ext;

  always_comb begin
    if (s1_a == '0) begin
      st_w = qrs_pkg::ST_AZERO;
    end else if (disc[DW-1]) begin
      st_w = qrs_pkg::ST_NONE;
    end else if (disc == '0) begin
      st_w = qrs_pkg::ST_ONE;
    end else begin
      st_w = qrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rad <= RADW'($unsigned(disc)) << (2 * F);
      s2_pl  <= {st_w, -(b_ext <<< F), {a_mag[CW-1:0], 1'b0}, a_ext[CW]};
    end
  end

  // square root chain
  logic            sq_valid [0:SQW];
  logic [RADW-1:0] sq_rad   [0:SQW];
  logic [SQW+1:0]  sq_rem   [0:SQW];
  logic [SQW-1:0]  sq_root  [0:SQW];
  logic [SPW-1:0]  sq_pl    [0:SQW];

  assign sq_valid[0] = s2_valid;
  assign sq_rad[0]   = s2_rad;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_pl[0]    = s2_pl;

  for (genvar i = 0; i < SQW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.SQW(SQW), .PW(SPW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (sq_valid[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_pl    (sq_pl[i]),
      .out_valid(sq_valid[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_pl   (sq_pl[i+1])
    );
  end

  // stage 3: numerators and quotient signs
  logic [1:0]           sq_st;
  logic signed [NW-1:0] sq_nb, sq_ext, num_p, num_m, mag_p, mag_m;
  logic [DENW-1:0]      sq_den;
  logic                 sq_aneg;
  logic                 s3_valid;
  logic [DENW-1:0]      s3_den;
  logic [QW-1:0]        s3_num [2];
  logic [DPW-1:0]       s3_pl;

  assign {sq_st, sq_nb, sq_den, sq_aneg} = sq_pl[SQW];
  assign sq_ext = NW'(sq_root[SQW]);
  assign num_p  = sq_nb + sq_ext;
  assign num_m  = sq_nb - sq_ext;
  assign mag_p  = num_p[NW-1] ? -num_p : num_p;
  assign mag_m  = num_m[NW-1] ? -num_m : num_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= sq_valid[SQW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_den    <= sq_den;
      s3_num[0] <= mag_p[QW-1:0];
      s3_num[1] <= mag_m[QW-1:0];
      s3_pl     <= {sq_st, num_p[NW-1] ^ sq_aneg, num_m[NW-1] ^ sq_aneg};
    end
  end

  // divider chain
  logic            dv_valid [0:QW];
  logic [DENW-1:0] dv_den   [0:QW];
  logic [QW-1:0]   dv_num   [0:QW][2];
  logic [DENW:0]   dv_rem   [0:QW][2];
  logic [DPW-1:0]  dv_pl    [0:QW];

  assign dv_valid[0]  = s3_valid;
  assign dv_den[0]    = s3_den;
  assign dv_num[0]    = s3_num;
  assign dv_rem[0][0] = '0;
  assign dv_rem[0][1] = '0;
  assign dv_pl[0]     = s3_pl;

  for (genvar j = 0; j < QW; j++) begin : g_div
    qrs_div_cell #(.QW(QW), .DENW(DENW), .PW(DPW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv_valid[j]),
      .in_den   (dv_den[j]),
      .in_num   (dv_num[j]),
      .in_rem   (dv_rem[j]),
      .in_pl    (dv_pl[j]),
      .out_valid(dv_valid[j+1]),
      .out_den  (dv_den[j+1]),
      .out_num  (dv_num[j+1]),
      .out_rem  (dv_rem[j+1]),
      .out_pl   (dv_pl[j+1])
    );
  end

  // output stage: sign, saturate, blank absent roots
  qrs_pkg::status_t     dv_st;
  logic                 dv_neg [2];
  logic signed [SW-1:0] q_s    [2];
  logic signed [OW-1:0] q_o    [2];
  logic                 no_root;
  qrs_pkg::status_t     out_st;

  assign dv_st     = qrs_pkg::status_t'(dv_pl[QW][3:2]);
  assign dv_neg[0] = dv_pl[QW][1];
  assign dv_neg[1] = dv_pl[QW][0];
  assign no_root   = (dv_st == qrs_pkg::ST_NONE) || (dv_st == qrs_pkg::ST_AZERO);

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      q_s[k] = dv_neg[k] ? -SW'(dv_num[QW][k]) : SW'(dv_num[QW][k]);
      if (no_root) begin
        q_o[k] = '0;
      end else if (q_s[k] > OMAX) begin
        q_o[k] = OW'(OMAX);
      end else if (q_s[k] < OMIN) begin
        q_o[k] = OW'(OMIN);
      end else begin
        q_o[k] = OW'(q_s[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st     <= dv_st;
      root_plus  <= q_o[0];
      root_minus <= q_o[1];
    end
  end

  assign root_status = out_st;

`ifndef NO_ASSERTIONS
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_st == qrs_pkg::ST_NONE) || (out_st == qrs_pkg::ST_AZERO))
      |-> (root_plus == '0) && (root_minus == '0))
    else $error("absent roots not zero");

  a_repeated_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_st == qrs_pkg::ST_ONE) |-> (root_plus == root_minus))
    else $error("repeated root differs");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");
`endif

endmodule

[sv/qrs_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one registered step of the square root chain
// Retires one root bit per cell from the top bit pair of the radicand.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
  parameter int SQW = 33,
  parameter int PW  = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2*SQW-1:0] in_rad,
  input  logic [SQW+1:0]   in_rem,
  input  logic [SQW-1:0]   in_root,
  input  logic [PW-1:0]    in_pl,
  output logic             out_valid,
  output logic [2*SQW-1:0] out_rad,
  output logic [SQW+1:0]   out_rem,
  output logic [SQW-1:0]   out_root,
  output logic [PW-1:0]    out_pl
);

  logic [SQW+1:0] rem_t;
  logic [SQW+1:0] trial;
  logic           ge;

  // remainder stays below 2*root+1, so its low SQW bits are all that matter
  assign rem_t = {in_rem[SQW-1:0], in_rad[2*SQW-1 -: 2]};
  assign trial = {in_root, 2'b01};
  assign ge    = (rem_t >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rad  <= in_rad << 2;
      out_rem  <= ge ? (rem_t - trial) : rem_t;
      out_root <= {in_root[SQW-2:0], ge};
      out_pl   <= in_pl;
    end
  end

endmodule

[sv/qrs_div_cell.sv]
// ----------------------------------------------------------------------------
// qrs_div_cell: one registered step of the restoring divider chain
// Two lanes (plus and minus root) share the divisor; one quotient bit each.
// ----------------------------------------------------------------------------
module qrs_div_cell #(
  parameter int QW   = 34,
  parameter int DENW = 17,
  parameter int PW   = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [DENW-1:0] in_den,
  input  logic [QW-1:0]   in_num [2],
  input  logic [DENW:0]   in_rem [2],
  input  logic [PW-1:0]   in_pl,
  output logic            out_valid,
  output logic [DENW-1:0] out_den,
  output logic [QW-1:0]   out_num [2],
  output logic [DENW:0]   out_rem [2],
  output logic [PW-1:0]   out_pl
);

  logic [DENW:0] rem_t [2];
  logic          ge    [2];

  // numerator register doubles as quotient register: bits shift in at the bottom
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rem_t[k] = {in_rem[k][DENW-1:0], in_num[k][QW-1]};
      ge[k]    = (rem_t[k] >= {1'b0, in_den});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_den <= in_den;
      out_pl  <= in_pl;
      for (int k = 0; k < 2; k++) begin
        out_rem[k] <= ge[k] ? (rem_t[k] - {1'b0, in_den}) : rem_t[k];
        out_num[k] <= {in_num[k][QW-2:0], ge[k]};
      end
    end
  end

endmodule
